### rtl/calendar_to_epoch_seconds_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the calendar to epoch seconds converter
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef CALENDAR_TO_EPOCH_SECONDS_ASSERT_SVH
`define CALENDAR_TO_EPOCH_SECONDS_ASSERT_SVH

`ifndef SYNTHESIS

// Check that is switched off while reset is high.
`define CET_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Check that also holds during reset.
`define CET_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`else

`define CET_ASSERT(lbl, clk, rst, prop)
`define CET_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

### rtl/cet_pkg.sv
// ----------------------------------------------------------------------------
// cet_pkg
// Shared widths, constants, codes and the month-length table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cet_pkg;

   localparam int SEC_W   = 6;
   localparam int MIN_W   = 6;
   localparam int HOUR_W  = 5;
   localparam int DAY_W   = 5;
   localparam int MONTH_W = 4;
   localparam int YEAR_W  = 12;
   localparam int ACC_W   = 32;
   localparam int TOD_W   = 17;

   localparam logic [ACC_W-1:0]   SECS_PER_DAY  = 32'd86400;
   localparam logic [TOD_W-1:0]   SECS_PER_HOUR = 17'd3600;
   localparam logic [TOD_W-1:0]   SECS_PER_MIN  = 17'd60;
   localparam logic [YEAR_W-1:0]  BASE_YEAR     = 12'd2000;
   localparam logic [ACC_W-1:0]   DAYS_COMMON   = 32'd365;
   localparam logic [ACC_W-1:0]   DAYS_LEAP     = 32'd366;
   localparam logic [MONTH_W-1:0] FIRST_MONTH   = 4'd1;
   localparam logic [MONTH_W-1:0] LAST_MONTH    = 4'd12;
   localparam logic [MONTH_W-1:0] MONTH_LIMIT   = 4'd13;

   // Accumulator operation codes.
   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_CLEAR,
      ACC_ADD,
      ACC_SCALE
   } acc_code_type;

   typedef struct packed {
      acc_code_type     code;
      logic [ACC_W-1:0] addend;
   } acc_op_type;

   // Days in a month; months outside one to twelve contribute nothing.
   function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
      logic [DAY_W-1:0] d;
      begin
         unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    d = 5'd30;
            4'd2:                                       d = leap ? 5'd29 : 5'd28;
            default:                                    d = 5'd0;
         endcase
         return d;
      end
   endfunction

endpackage

### rtl/cet_req_if.sv
// ----------------------------------------------------------------------------
// cet_req_if
// Request channel: one calendar reading with valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface cet_req_if;
   logic                         valid;
   logic                         ready;
   logic                         clock_ready;
   logic [cet_pkg::SEC_W-1:0]    sec;
   logic [cet_pkg::MIN_W-1:0]    minute;
   logic [cet_pkg::HOUR_W-1:0]   hour;
   logic [cet_pkg::DAY_W-1:0]    day_of_month;
   logic [cet_pkg::MONTH_W-1:0]  month_num;
   logic [cet_pkg::YEAR_W-1:0]   year_num;

   modport source (output valid, clock_ready, sec, minute, hour, day_of_month,
                   month_num, year_num, input ready);
   modport sink (input valid, clock_ready, sec, minute, hour, day_of_month,
                 month_num, year_num, output ready);
endinterface

### rtl/cet_rsp_if.sv
// ----------------------------------------------------------------------------
// cet_rsp_if
// Result channel: seconds since 2000 and the valid flag, with handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface cet_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [cet_pkg::ACC_W-1:0]   epoch_seconds;
   logic                        time_valid;

   modport source (output valid, epoch_seconds, time_valid, input ready);
   modport sink (input valid, epoch_seconds, time_valid, output ready);
endinterface

### rtl/cet_leap.sv
// ----------------------------------------------------------------------------
// cet_leap
// Two-stage leap-year check of a year by reciprocal multiplication.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cet_leap (
   input  logic                         clock,
   input  logic [cet_pkg::YEAR_W-1:0]   year,
   output logic                         leap
);

   // year / 100 as (year * 5243) >> 19, exact for every 12-bit year.
   localparam logic [12:0] RECIP_100 = 13'd5243;
   localparam int          RECIP_SH  = 19;

   logic [24:0]                 prod;
   logic [5:0]                  quot_in, quot_ff;
   logic [cet_pkg::YEAR_W-1:0]  year_ff;
   logic [cet_pkg::YEAR_W-1:0]  hundreds;
   logic                        leap_in, leap_ff;

   assign prod    = 25'(year) * 25'(RECIP_100);
   assign quot_in = prod[RECIP_SH +: 6];

   // quot * 100 built from shifts.
   assign hundreds = (12'(quot_ff) << 6) + (12'(quot_ff) << 5) + (12'(quot_ff) << 2);

   // Divisible by 4, and either not by 100 or also by 400.
   assign leap_in = (year_ff[1:0] == 2'd0) &&
                    ((hundreds != year_ff) || (quot_ff[1:0] == 2'd0));

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      year_ff <= year;
      leap_ff <= leap_in;
   end

   assign leap = leap_ff;

endmodule

### rtl/cet_accum.sv
// ----------------------------------------------------------------------------
// cet_accum
// Shared 32-bit accumulator: hold, clear, add, or scale days to seconds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cet_accum (
   input  logic                        clock,
   input  cet_pkg::acc_op_type         op,
   output logic [cet_pkg::ACC_W-1:0]   acc
);

   logic [cet_pkg::ACC_W-1:0] acc_ff;

   // All arithmetic wraps modulo 2^32.
   always_ff @(posedge clock) begin
      unique case (op.code)
         cet_pkg::ACC_HOLD:  acc_ff <= acc_ff;
         cet_pkg::ACC_CLEAR: acc_ff <= '0;
         cet_pkg::ACC_ADD:   acc_ff <= acc_ff + op.addend;
         cet_pkg::ACC_SCALE: acc_ff <= acc_ff * cet_pkg::SECS_PER_DAY;
         default:            acc_ff <= acc_ff;
      endcase
   end

   assign acc = acc_ff;

endmodule

### rtl/calendar_to_epoch_seconds.sv
// ----------------------------------------------------------------------------
// calendar_to_epoch_seconds
// Converts a calendar reading into seconds elapsed since 2000-01-01 00:00:00.
// The sequencer adds the days of each whole year after 2000, then of each whole
// month, then the day of month, scales days to seconds and adds the time of day.
// A reading with the clock not ready skips the conversion. Either may wait longer
// while the previous result is still held. One request at a time: a new one
// is taken once the result is registered, also while that result waits.
// Reset: synchronous, active high; clears the sequencer and result valid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "calendar_to_epoch_seconds_assert.svh"

module calendar_to_epoch_seconds (
   input  logic           clock,
   input  logic           reset,
   cet_req_if.sink        req_if,
   cet_rsp_if.source      rsp_if
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_PREP,
      S_YEARS,
      S_MONTHS,
      S_DOM,
      S_SCALE,
      S_TOD,
      S_DONE
   } state_type;

   state_type state_ff;

   logic                                ready_ff;
   logic [cet_pkg::SEC_W-1:0]           sec_ff;
   logic [cet_pkg::MIN_W-1:0]           minute_ff;
   logic [cet_pkg::HOUR_W-1:0]          hour_ff;
   logic [cet_pkg::DAY_W-1:0]           dom_ff;
   logic [cet_pkg::MONTH_W-1:0]         mon_ff;
   logic [cet_pkg::YEAR_W-1:0]          yr_ff;

   logic [cet_pkg::YEAR_W-1:0]          y_ff;
   logic [1:0]                          c4_ff;
   logic [6:0]                          c100_ff;
   logic [8:0]                          c400_ff;
   logic [cet_pkg::MONTH_W-1:0]         m_ff;

   logic                                rsp_valid_ff;
   logic [cet_pkg::ACC_W-1:0]           epoch_ff;
   logic                                tv_ff;

   logic                                accept;
   logic                                y_leap;
   logic                                yr_leap;
   logic                                years_more;
   logic                                months_more;
   logic [cet_pkg::TOD_W-1:0]           tod;
   logic [cet_pkg::ACC_W-1:0]           acc;
   cet_pkg::acc_op_type                 acc_op;

   assign req_if.ready = (state_ff == S_IDLE);
   assign accept       = req_if.valid && req_if.ready;

   // Leap test of the loop year from its running remainders.
   assign y_leap = ((c4_ff == 2'd0) && (c100_ff != 7'd0)) || (c400_ff == 9'd0);

   assign years_more  = (y_ff < yr_ff);
   assign months_more = (m_ff < mon_ff) && (m_ff <= cet_pkg::LAST_MONTH);

   assign tod = (cet_pkg::TOD_W'(hour_ff) * cet_pkg::SECS_PER_HOUR) +
                (cet_pkg::TOD_W'(minute_ff) * cet_pkg::SECS_PER_MIN) +
                cet_pkg::TOD_W'(sec_ff);

   cet_leap u_leap (
      .clock (clock),
      .year  (yr_ff),
      .leap  (yr_leap)
   );

   always_comb begin
      acc_op.code   = cet_pkg::ACC_HOLD;
      acc_op.addend = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               acc_op.code = cet_pkg::ACC_CLEAR;
            end
         end
         S_YEARS: begin
            if (years_more) begin
               acc_op.code   = cet_pkg::ACC_ADD;
               acc_op.addend = y_leap ? cet_pkg::DAYS_LEAP : cet_pkg::DAYS_COMMON;
            end
         end
         S_MONTHS: begin
            if (months_more) begin
               acc_op.code   = cet_pkg::ACC_ADD;
               acc_op.addend = cet_pkg::ACC_W'(cet_pkg::month_days(m_ff, yr_leap));
            end
         end
         S_DOM: begin
            // Day zero wraps to minus one day.
            acc_op.code   = cet_pkg::ACC_ADD;
            acc_op.addend = cet_pkg::ACC_W'(dom_ff) - cet_pkg::ACC_W'(1);
         end
         S_SCALE: begin
            acc_op.code = cet_pkg::ACC_SCALE;
         end
         S_TOD: begin
            acc_op.code   = cet_pkg::ACC_ADD;
            acc_op.addend = cet_pkg::ACC_W'(tod);
         end
         S_DONE: begin
            acc_op.code = cet_pkg::ACC_HOLD;
         end
         default: begin
            acc_op.code = cet_pkg::ACC_HOLD;
         end
      endcase
   end

   cet_accum u_accum (
      .clock (clock),
      .op    (acc_op),
      .acc   (acc)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if ((state_ff == S_DONE) && (!rsp_valid_ff || rsp_if.ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  ready_ff  <= req_if.clock_ready;
                  sec_ff    <= req_if.sec;
                  minute_ff <= req_if.minute;
                  hour_ff   <= req_if.hour;
                  dom_ff    <= req_if.day_of_month;
                  mon_ff    <= req_if.month_num;
                  yr_ff     <= req_if.year_num;
                  y_ff      <= cet_pkg::BASE_YEAR;
                  c4_ff     <= '0;
                  c100_ff   <= '0;
                  c400_ff   <= '0;
                  m_ff      <= cet_pkg::FIRST_MONTH;
                  // A reading taken before the clock is ready skips the work.
                  state_ff  <= req_if.clock_ready ? S_PREP : S_DONE;
               end
            end
            S_PREP: begin
               state_ff <= S_YEARS;
            end
            S_YEARS: begin
               if (years_more) begin
                  y_ff    <= y_ff + 12'd1;
                  c4_ff   <= c4_ff + 2'd1;
                  c100_ff <= (c100_ff == 7'd99) ? 7'd0 : c100_ff + 7'd1;
                  c400_ff <= (c400_ff == 9'd399) ? 9'd0 : c400_ff + 9'd1;
               end else begin
                  state_ff <= S_MONTHS;
               end
            end
            S_MONTHS: begin
               if (months_more) begin
                  m_ff <= m_ff + 4'd1;
               end else begin
                  state_ff <= S_DOM;
               end
            end
            S_DOM: begin
               state_ff <= S_SCALE;
            end
            S_SCALE: begin
               state_ff <= S_TOD;
            end
            S_TOD: begin
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_if.ready) begin
                  epoch_ff     <= ready_ff ? acc : '0;
                  tv_ff        <= ready_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.epoch_seconds = epoch_ff;
   assign rsp_if.time_valid    = tv_ff;

   `CET_ASSERT(a_busy_after_accept, clock, reset, accept |=> !req_if.ready)
   `CET_ASSERT(a_invalid_is_zero, clock, reset, (rsp_valid_ff && !tv_ff) |-> (epoch_ff == '0))
   `CET_ASSERT(a_month_bound, clock, reset, (state_ff == S_MONTHS) |-> (m_ff <= cet_pkg::MONTH_LIMIT))
   `CET_ASSERT_ALWAYS(a_reset_idle, clock, $past(reset) |-> (!rsp_if.valid && (state_ff == S_IDLE)))

endmodule
